>>> hdl/sa8d_pkg.sv
// shared types and constants for the 16x16 sa8d cost block
`default_nettype none
package sa8d_pkg;

  localparam int unsigned HALF_LANES = 8;
  localparam int unsigned LANES      = 16;
  localparam int unsigned PASS_ROWS  = 8;
  localparam int unsigned HIST_ROWS  = PASS_ROWS - 1;
  localparam int unsigned GROUPS     = 4;
  localparam int unsigned FOLD_DEPTH = 6;

  localparam logic [3:0] LAST_ROW  = 4'd15;
  localparam logic [2:0] LAST_SLOT = 3'd7;

  typedef logic        [7:0]  pixel_t;
  typedef logic signed [8:0]  diff_t;
  typedef logic signed [11:0] coef_t;
  typedef logic        [14:0] lane_sum_t;
  typedef logic        [16:0] group_sum_t;
  typedef logic        [18:0] pass_sum_t;
  typedef logic        [20:0] total_t;
  typedef logic        [19:0] cost_t;
  typedef logic        [2:0]  half_idx_t;

  // lane permutation between butterfly stages of one half-row
  localparam half_idx_t HALF_ORDER [HALF_LANES] = '{
    3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7
  };

  typedef struct packed {
    logic c;
    logic m;
    logic s;
  } lane_en_t;

  typedef struct packed {
    logic g;
    logic p;
    logic acc;
    logic fin;
  } merge_en_t;

endpackage
`default_nettype wire

>>> hdl/sa8d_hrow.sv
// 8-point horizontal hadamard of one half-row of pixel differences
`default_nettype none
module sa8d_hrow (
  input  wire logic [63:0]     cur_i,
  input  wire logic [63:0]     ref_i,
  output sa8d_pkg::coef_t      coef_o [sa8d_pkg::HALF_LANES]
);
  import sa8d_pkg::*;

  diff_t              d  [HALF_LANES];
  logic signed [9:0]  s1 [HALF_LANES];
  logic signed [9:0]  r1 [HALF_LANES];
  logic signed [10:0] s2 [HALF_LANES];
  logic signed [10:0] r2 [HALF_LANES];

  always_comb begin
    for (int k = 0; k < HALF_LANES; k++) begin
      d[k] = $signed({1'b0, cur_i[8*k +: 8]}) - $signed({1'b0, ref_i[8*k +: 8]});
    end
    for (int p = 0; p < HALF_LANES / 2; p++) begin
      s1[2*p]   = 10'(d[2*p]) - 10'(d[2*p+1]);
      s1[2*p+1] = 10'(d[2*p]) + 10'(d[2*p+1]);
    end
    for (int i = 0; i < HALF_LANES; i++) begin
      r1[i] = s1[HALF_ORDER[i]];
    end
    for (int p = 0; p < HALF_LANES / 2; p++) begin
      s2[2*p]   = 11'(r1[2*p]) - 11'(r1[2*p+1]);
      s2[2*p+1] = 11'(r1[2*p]) + 11'(r1[2*p+1]);
    end
    for (int i = 0; i < HALF_LANES; i++) begin
      r2[i] = s2[HALF_ORDER[i]];
    end
    for (int p = 0; p < HALF_LANES / 2; p++) begin
      coef_o[2*p]   = 12'(r2[2*p]) - 12'(r2[2*p+1]);
      coef_o[2*p+1] = 12'(r2[2*p]) + 12'(r2[2*p+1]);
    end
  end

endmodule
`default_nettype wire

>>> hdl/sa8d_lane.sv
// one lane of the vertical fold: butterflies, magnitudes, pair max, lane sum
`default_nettype none
module sa8d_lane (
  input  wire logic               clk_i,
  input  sa8d_pkg::lane_en_t      en_i,
  input  sa8d_pkg::coef_t         a_i [sa8d_pkg::PASS_ROWS],
  output sa8d_pkg::lane_sum_t     sum_o
);
  import sa8d_pkg::*;

  logic signed [12:0] b   [PASS_ROWS];
  logic signed [13:0] c_d [PASS_ROWS];
  logic signed [13:0] c_q [PASS_ROWS];
  logic        [12:0] mg  [PASS_ROWS];
  logic        [12:0] mx_d [GROUPS];
  logic        [12:0] mx_q [GROUPS];
  lane_sum_t          sum_d;
  lane_sum_t          sum_q;

  function automatic logic [12:0] mag13(input logic signed [13:0] x);
    logic [13:0] u;
    u = x[13] ? 14'(-x) : 14'(x);
    return u[12:0];
  endfunction

  always_comb begin
    for (int p = 0; p < PASS_ROWS / 2; p++) begin
      b[2*p]   = 13'(a_i[2*p]) + 13'(a_i[2*p+1]);
      b[2*p+1] = 13'(a_i[2*p]) - 13'(a_i[2*p+1]);
    end
    for (int q = 0; q < 2; q++) begin
      c_d[4*q]   = 14'(b[4*q])   + 14'(b[4*q+2]);
      c_d[4*q+2] = 14'(b[4*q])   - 14'(b[4*q+2]);
      c_d[4*q+1] = 14'(b[4*q+1]) + 14'(b[4*q+3]);
      c_d[4*q+3] = 14'(b[4*q+1]) - 14'(b[4*q+3]);
    end
    for (int r = 0; r < PASS_ROWS; r++) begin
      mg[r] = mag13(c_q[r]);
    end
    // rows four apart pair up for the max
    for (int j = 0; j < GROUPS; j++) begin
      mx_d[j] = (mg[j] > mg[j+4]) ? mg[j] : mg[j+4];
    end
    sum_d = 15'(mx_q[0]) + 15'(mx_q[1]) + 15'(mx_q[2]) + 15'(mx_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      c_q <= c_d;
    end
    if (en_i.m) begin
      mx_q <= mx_d;
    end
    if (en_i.s) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

>>> hdl/sa8d_merge.sv
// merging tree over the lane sums and block total accumulator
`default_nettype none
module sa8d_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  sa8d_pkg::merge_en_t     en_i,
  input  sa8d_pkg::lane_sum_t     lane_sum_i [sa8d_pkg::LANES],
  output sa8d_pkg::cost_t         cost_o
);
  import sa8d_pkg::*;

  group_sum_t group_d [GROUPS];
  group_sum_t group_q [GROUPS];
  pass_sum_t  pass_d;
  pass_sum_t  pass_q;
  total_t     total_q;
  total_t     total_inc;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_d[g] = 17'(lane_sum_i[4*g])   + 17'(lane_sum_i[4*g+1])
                 + 17'(lane_sum_i[4*g+2]) + 17'(lane_sum_i[4*g+3]);
    end
    pass_d = 19'(group_q[0]) + 19'(group_q[1]) + 19'(group_q[2]) + 19'(group_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.g) begin
      group_q <= group_d;
    end
    if (en_i.p) begin
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (en_i.fin) begin
      total_q <= '0;
    end else if (en_i.acc) begin
      total_q <= total_q + 21'(pass_q);
    end
  end

  // rounded half of the block total
  assign total_inc = total_q + 21'd1;
  assign cost_o    = total_inc[20:1];

endmodule
`default_nettype wire

>>> hdl/sa8d_16x16_hadamard_cost.sv
// top level of the 16x16 sa8d cost engine
// Usage: one request carries one pixel row of a 16x16 block, 16 current and 16
// reference pixels packed as four 64-bit words (byte k in bits 8k+7:8k).
// Rows are sent in order, row 0 first; a row may be sent every cycle.
// After rows 0-7 and again after rows 8-15 all 16 lanes fold their column of
// eight transformed rows at once; the merging tree adds the lane sums into the
// block total. One result, the rounded halved total, follows each 16th row.
// Throughput: one row per cycle while in_stall_o is low; the lanes see a new
// column set once every eight rows, so folds never overlap.
// Result path: once the request carrying row 15 is taken, the block passes
// through three lane stages, two merge stages, accumulate and the output
// register to out_valid_o, then stays there until the receiver takes it.
// Stall: while a result is held on the output, in_stall_o rises only for the
// request carrying the next block's row 15; all other rows keep flowing.
// Reset: the row counter, block total and all valid flags clear; the row
// history holds no meaning until the first eight rows of a pass are in.
`default_nettype none
module sa8d_16x16_hadamard_cost (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [63:0]         cur_left_pixels_i,
  input  wire logic [63:0]         cur_right_pixels_i,
  input  wire logic [63:0]         ref_left_pixels_i,
  input  wire logic [63:0]         ref_right_pixels_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      sa8d_pkg::cost_t     sa8d_cost_o
);
  import sa8d_pkg::*;

  logic                 in_acc;
  logic [3:0]           row_q;
  coef_t                coef_l [HALF_LANES];
  coef_t                coef_r [HALF_LANES];
  coef_t                hrow_q [LANES];
  logic                 hv_q;
  logic                 hfold_q;
  logic                 hlast_q;
  coef_t                hist_q [HIST_ROWS][LANES];
  coef_t                col [LANES][PASS_ROWS];
  logic [FOLD_DEPTH-1:0] fv_q;
  logic [FOLD_DEPTH-1:0] lv_q;
  lane_en_t             lane_en;
  merge_en_t            merge_en;
  lane_sum_t            lane_sum [LANES];
  cost_t                cost_d;
  cost_t                cost_q;
  logic                 out_valid_q;

  // a held result blocks only the row that would make the next one
  assign in_stall_o = out_valid_q && (row_q == LAST_ROW);
  assign in_acc     = in_valid_i && !in_stall_o;

  sa8d_hrow u_hrow_l (
    .cur_i  (cur_left_pixels_i),
    .ref_i  (ref_left_pixels_i),
    .coef_o (coef_l)
  );

  sa8d_hrow u_hrow_r (
    .cur_i  (cur_right_pixels_i),
    .ref_i  (ref_right_pixels_i),
    .coef_o (coef_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      hv_q    <= 1'b0;
      hfold_q <= 1'b0;
      hlast_q <= 1'b0;
      fv_q    <= '0;
      lv_q    <= '0;
    end else begin
      hv_q <= in_acc;
      if (in_acc) begin
        row_q   <= row_q + 4'd1;
        hfold_q <= (row_q[2:0] == LAST_SLOT);
        hlast_q <= (row_q == LAST_ROW);
      end
      fv_q <= {fv_q[FOLD_DEPTH-2:0], hv_q && hfold_q};
      lv_q <= {lv_q[FOLD_DEPTH-2:0], hlast_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < HALF_LANES; k++) begin
        hrow_q[k]              <= coef_l[k];
        hrow_q[HALF_LANES + k] <= coef_r[k];
      end
    end
    // history of the seven previous rows, oldest at index 0
    if (hv_q) begin
      for (int r = 0; r < HIST_ROWS - 1; r++) begin
        hist_q[r] <= hist_q[r+1];
      end
      hist_q[HIST_ROWS-1] <= hrow_q;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int r = 0; r < HIST_ROWS; r++) begin
        col[l][r] = hist_q[r][l];
      end
      col[l][PASS_ROWS-1] = hrow_q[l];
    end
  end

  assign lane_en.c = hv_q && hfold_q;
  assign lane_en.m = fv_q[0];
  assign lane_en.s = fv_q[1];

  assign merge_en.g   = fv_q[2];
  assign merge_en.p   = fv_q[3];
  assign merge_en.acc = fv_q[4];
  assign merge_en.fin = fv_q[5] && lv_q[5];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sa8d_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .a_i   (col[l]),
      .sum_o (lane_sum[l])
    );
  end

  sa8d_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (merge_en),
    .lane_sum_i (lane_sum),
    .cost_o     (cost_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (merge_en.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_en.fin) begin
      cost_q <= cost_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sa8d_cost_o = cost_q;

endmodule
`default_nettype wire

>>> tb/tb_sa8d_16x16_hadamard_cost.sv
// self-checking testbench for the 16x16 sa8d cost engine
`timescale 1ns / 1ps
module tb_sa8d_16x16_hadamard_cost;
  import sa8d_pkg::*;

  localparam int RANDOM_BLOCKS = 58;
  localparam int ROW_TOTAL     = 16 + RANDOM_BLOCKS * 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [63:0] cur_left;
    logic [63:0] cur_right;
    logic [63:0] ref_left;
    logic [63:0] ref_right;
  } pixel_row_t;

  typedef enum int {
    MIX_NOISE,
    MIX_NEAR,
    MIX_EXTREME,
    MIX_MATCH,
    MIX_PER_ROW
  } row_mix_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        row_valid = 1'b0;
  logic        row_stall;
  pixel_row_t  row_payload = '0;
  logic        cost_valid;
  logic        cost_stall = 1'b0;
  cost_t       cost;

  // predictor state
  coef_t       row_hist [PASS_ROWS][LANES];
  logic [3:0]  row_pos = '0;
  total_t      cost_total = '0;

  pixel_row_t  pending_rows [$];
  cost_t       expected_costs [$];
  int          rows_taken = 0;
  int          costs_checked = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  sa8d_16x16_hadamard_cost u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (row_valid),
    .in_stall_o         (row_stall),
    .cur_left_pixels_i  (row_payload.cur_left),
    .cur_right_pixels_i (row_payload.cur_right),
    .ref_left_pixels_i  (row_payload.ref_left),
    .ref_right_pixels_i (row_payload.ref_right),
    .out_valid_o        (cost_valid),
    .out_stall_i        (cost_stall),
    .sa8d_cost_o        (cost)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int mag(int x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic int bigger(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // fold of the eight stored rows of one pass, summed over all lanes
  function automatic int fold_pass_sum();
    int col [PASS_ROWS];
    int b [PASS_ROWS];
    int sum;
    sum = 0;
    for (int l = 0; l < LANES; l++) begin
      for (int r = 0; r < PASS_ROWS; r++) col[r] = int'(row_hist[r][l]);
      for (int p = 0; p < PASS_ROWS / 2; p++) begin
        b[2*p]   = col[2*p] + col[2*p+1];
        b[2*p+1] = col[2*p] - col[2*p+1];
      end
      sum += bigger(mag(b[0] + b[2]), mag(b[4] + b[6]));
      sum += bigger(mag(b[1] + b[3]), mag(b[5] + b[7]));
      sum += bigger(mag(b[0] - b[2]), mag(b[4] - b[6]));
      sum += bigger(mag(b[1] - b[3]), mag(b[5] - b[7]));
    end
    return sum;
  endfunction

  // horizontal transform of one row, storage, and the pass and block bookkeeping
  function automatic void predict_row(pixel_row_t row);
    int lane [LANES];
    int shuf [LANES];
    int a;
    int b;
    int j;
    logic [2:0] slot;
    for (int k = 0; k < 8; k++) begin
      lane[k]     = int'(row.cur_left[8*k +: 8]) - int'(row.ref_left[8*k +: 8]);
      lane[8 + k] = int'(row.cur_right[8*k +: 8]) - int'(row.ref_right[8*k +: 8]);
    end
    for (int st = 0; st < 3; st++) begin
      for (int p = 0; p < LANES / 2; p++) begin
        a = lane[2*p];
        b = lane[2*p+1];
        lane[2*p]   = a - b;
        lane[2*p+1] = a + b;
      end
      if (st < 2) begin
        // even lanes of each half first, then odd lanes
        for (int i = 0; i < LANES; i++) begin
          j = i & 7;
          shuf[i] = lane[(i & 8) | ((j < 4) ? 2 * j : 2 * (j - 4) + 1)];
        end
        lane = shuf;
      end
    end
    slot = row_pos[2:0];
    for (int l = 0; l < LANES; l++) row_hist[slot][l] = coef_t'(lane[l]);
    if (slot == LAST_SLOT) begin
      cost_total = cost_total + total_t'(fold_pass_sum());
      if (row_pos == LAST_ROW) begin
        expected_costs.push_back(cost_t'((int'(cost_total) + 1) >> 1));
        cost_total = '0;
      end
    end
    row_pos = row_pos + 4'd1;
  endfunction

  function automatic pixel_row_t random_row(row_mix_e mix);
    pixel_row_t row;
    logic [7:0] c;
    logic [7:0] p;
    int q;
    for (int px = 0; px < 16; px++) begin
      c = 8'($urandom);
      case (mix)
        MIX_NEAR: begin
          q = int'(c) + int'($urandom_range(8)) - 4;
          if (q < 0) q = 0;
          if (q > 255) q = 255;
          p = 8'(q);
        end
        MIX_EXTREME: begin
          c = $urandom_range(1) ? 8'hff : 8'h00;
          p = $urandom_range(1) ? 8'hff : 8'h00;
        end
        MIX_MATCH: p = c;
        default: p = 8'($urandom);
      endcase
      if (px < 8) begin
        row.cur_left[8*px +: 8] = c;
        row.ref_left[8*px +: 8] = p;
      end else begin
        row.cur_right[8*(px-8) +: 8] = c;
        row.ref_right[8*(px-8) +: 8] = p;
      end
    end
    return row;
  endfunction

  // traffic mix follows progress: clean, sender gaps, receiver stalls, both
  function automatic int traffic_phase();
    int ph;
    ph = (rows_taken * 4) / ROW_TOTAL;
    return (ph > 3) ? 3 : ph;
  endfunction

  function automatic int send_idle_pct();
    case (traffic_phase())
      1:       return 53;
      3:       return 38;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (traffic_phase())
      2:       return 53;
      3:       return 38;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, cost_t got, cost_t want);
    mismatches++;
    $display("[%0t] mismatch: %s, sa8d_cost got %0d expected %0d", $realtime, what, got, want);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid <= 1'b0;
    end else begin
      if (row_valid && !row_stall) begin
        predict_row(pending_rows.pop_front());
        rows_taken <= rows_taken + 1;
      end
      if (!row_valid || !row_stall) begin
        if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          row_valid   <= 1'b1;
          row_payload <= pending_rows[0];
        end else begin
          row_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_stall <= 1'b0;
    end else begin
      if (cost_valid && !cost_stall) begin
        costs_checked++;
        if (expected_costs.size() == 0) begin
          report_mismatch("result with none pending", cost, '0);
        end else if (cost !== expected_costs[0]) begin
          report_mismatch("wrong block cost", cost, expected_costs.pop_front());
        end else begin
          void'(expected_costs.pop_front());
        end
      end
      cost_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((row_valid && !row_stall) || (cost_valid && !cost_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    row_mix_e mix;
    logic [63:0] alt_a;
    logic [63:0] alt_b;
    alt_a = 64'h00ff00ff00ff00ff;
    alt_b = 64'hff00ff00ff00ff00;
    // directed block: zero, extreme and mixed-sign rows, then a checkerboard pass
    pending_rows.push_back('{64'h0, 64'h0, 64'h0, 64'h0});
    pending_rows.push_back('{'1, '1, 64'h0, 64'h0});
    pending_rows.push_back('{64'h0, 64'h0, '1, '1});
    pending_rows.push_back('{'1, '1, '1, '1});
    pending_rows.push_back('{alt_b, alt_b, alt_a, alt_a});
    pending_rows.push_back('{'1, 64'h0, 64'h0, '1});
    pending_rows.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210,
                             64'hfedcba9876543210, 64'h0123456789abcdef});
    pending_rows.push_back('{alt_a, 64'h0, 64'h0, alt_b});
    for (int r = 0; r < 8; r++) begin
      if (r % 2 == 0) pending_rows.push_back('{alt_a, alt_a, alt_b, alt_b});
      else            pending_rows.push_back('{alt_b, alt_b, alt_a, alt_a});
    end
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: mix = MIX_NOISE;
        4, 5:       mix = MIX_NEAR;
        6, 7:       mix = MIX_EXTREME;
        8:          mix = MIX_MATCH;
        default:    mix = MIX_PER_ROW;
      endcase
      for (int r = 0; r < 16; r++) begin
        if (mix == MIX_PER_ROW) pending_rows.push_back(random_row(row_mix_e'($urandom_range(3))));
        else                    pending_rows.push_back(random_row(mix));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rows_taken < ROW_TOTAL) @(posedge clk_i);
    while (expected_costs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d pixel rows (%0d blocks) through four traffic mixes", rows_taken,
             rows_taken / 16);
    $display("checked %0d block costs, %0d mismatches", costs_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
